// ----- rtl/ndc_pkg.sv -----
// Shared types, constants and reciprocal table for the density and connectivity block.
package ndc_pkg;

	localparam int CLASS_BITS    = 16;
	localparam int FIELD_W       = 16;
	localparam int OUT_W         = 16;
	localparam int FRACTION_BITS = 15;
	localparam int RING_SIZE     = 8;
	localparam int RING_LAST     = 7;

	// Pair counts reach twice the ring size, so the count needs one extra bit.
	localparam int CNT_W   = $clog2(2 * RING_SIZE + 1);
	localparam int NUM_DEN = 2 * RING_SIZE + 1;

	// The reciprocal is ceil(2^RECIP_BITS / den), and the quotient is the product
	// shifted down by RECIP_SHIFT. Nine spare bits keep the quotient exact for
	// every count up to sixteen.
	localparam int RECIP_BITS  = FRACTION_BITS + 9;
	localparam int RECIP_W     = RECIP_BITS + 1;
	localparam int RECIP_SHIFT = RECIP_BITS - FRACTION_BITS;
	localparam int PROD_W      = (CNT_W + RECIP_W > RECIP_SHIFT + OUT_W) ?
		(CNT_W + RECIP_W) : (RECIP_SHIFT + OUT_W);

	localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_BITS;

	typedef logic [RECIP_W-1:0] recip_t;

	// Entry 0 is zero, so a zero divisor gives a zero fraction.
	localparam recip_t RECIP_TAB [NUM_DEN] = '{
		recip_t'(64'd0),
		recip_t'((RECIP_ONE + 64'd0) / 64'd1),
		recip_t'((RECIP_ONE + 64'd1) / 64'd2),
		recip_t'((RECIP_ONE + 64'd2) / 64'd3),
		recip_t'((RECIP_ONE + 64'd3) / 64'd4),
		recip_t'((RECIP_ONE + 64'd4) / 64'd5),
		recip_t'((RECIP_ONE + 64'd5) / 64'd6),
		recip_t'((RECIP_ONE + 64'd6) / 64'd7),
		recip_t'((RECIP_ONE + 64'd7) / 64'd8),
		recip_t'((RECIP_ONE + 64'd8) / 64'd9),
		recip_t'((RECIP_ONE + 64'd9) / 64'd10),
		recip_t'((RECIP_ONE + 64'd10) / 64'd11),
		recip_t'((RECIP_ONE + 64'd11) / 64'd12),
		recip_t'((RECIP_ONE + 64'd12) / 64'd13),
		recip_t'((RECIP_ONE + 64'd13) / 64'd14),
		recip_t'((RECIP_ONE + 64'd14) / 64'd15),
		recip_t'((RECIP_ONE + 64'd15) / 64'd16)
	};

	// Register indexes on the configuration channel.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_CLASS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_MODE    = 2'd1;

	// Classified neighbourhood handed from the front end to the back end.
	typedef struct packed {
		logic                 cmatch;
		logic [RING_SIZE-1:0] nmatch;
		logic [RING_SIZE-1:0] nvalid;
	} class_item_t;

endpackage

// ----- rtl/ndc_front.sv -----
// Front end: accepts a neighbourhood and classifies each cell against the target class.
module ndc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ndc_pkg::FIELD_W-1:0]   target_class,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ndc_pkg::FIELD_W-1:0]   center_class,
	input  logic [ndc_pkg::FIELD_W-1:0]   nb_class [ndc_pkg::RING_SIZE],
	input  logic [ndc_pkg::RING_SIZE-1:0] neighbour_valid,
	input  logic                          center_valid,
	output logic                          item_valid,
	input  logic                          item_ready,
	output ndc_pkg::class_item_t          item
);

	ndc_pkg::class_item_t cls;
	ndc_pkg::class_item_t item_s1;
	logic                 valid_s1;
	logic [ndc_pkg::CLASS_BITS-1:0] key;

	// Compare the low class bits of every valid cell with the target.
	always_comb begin
		key        = target_class[ndc_pkg::CLASS_BITS-1:0];
		cls.cmatch = center_valid && (center_class[ndc_pkg::CLASS_BITS-1:0] == key);
		cls.nvalid = neighbour_valid;
		for (int k = 0; k < ndc_pkg::RING_SIZE; k++) begin
			cls.nmatch[k] = neighbour_valid[k] &&
				(nb_class[k][ndc_pkg::CLASS_BITS-1:0] == key);
		end
	end

	assign in_ready = !valid_s1 || item_ready;

	// Hold the classified beat until the queue takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ----- rtl/ndc_fifo.sv -----
// Two-entry queue between the front end and the back end.
module ndc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  ndc_pkg::class_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output ndc_pkg::class_item_t pop_item
);

	ndc_pkg::class_item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// Advance pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/ndc_back.sv -----
// Back end: counts matches and pairs, then forms both fractions by reciprocal multiply.
module ndc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        mean_mode,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  ndc_pkg::class_item_t        item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ndc_pkg::OUT_W-1:0]   density,
	output logic [ndc_pkg::OUT_W-1:0]   connectivity
);

	localparam int CW = ndc_pkg::CNT_W;
	localparam int PW = ndc_pkg::PROD_W;
	localparam int RS = ndc_pkg::RECIP_SHIFT;
	localparam int OW = ndc_pkg::OUT_W;

	logic [ndc_pkg::RING_SIZE-1:0] prev_m;
	logic [ndc_pkg::RING_SIZE-1:0] prev_v;
	logic [ndc_pkg::RING_SIZE-1:0] c_pair;
	logic [ndc_pkg::RING_SIZE-1:0] c_join;
	logic [ndc_pkg::RING_SIZE-1:0] r_pair;
	logic [ndc_pkg::RING_SIZE-1:0] r_join;
	logic [CW-1:0] d_num;
	logic [CW-1:0] d_den;
	logic [CW-1:0] c_num;
	logic [CW-1:0] c_den;

	logic          valid_s2;
	logic [CW-1:0] d_num_s2;
	logic [CW-1:0] d_den_s2;
	logic [CW-1:0] c_num_s2;
	logic [CW-1:0] c_den_s2;

	logic          valid_s3;
	logic [PW-1:0] d_prod_s3;
	logic [PW-1:0] c_prod_s3;

	logic          out_valid_q;
	logic [OW-1:0] density_q;
	logic [OW-1:0] connectivity_q;

	logic ready_out;
	logic ready_s3;
	logic ready_s2;

	// Each stage moves when it is empty or the next one moves.
	assign ready_out  = !out_valid_q || out_ready;
	assign ready_s3   = !valid_s3 || ready_out;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign item_ready = ready_s2;

	// Flag the counted and joined pairs, centre to ring and around the ring, and form both counts.
	always_comb begin
		for (int k = 0; k < ndc_pkg::RING_SIZE; k++) begin
			prev_m[k] = item.nmatch[(k + ndc_pkg::RING_LAST) % ndc_pkg::RING_SIZE];
			prev_v[k] = item.nvalid[(k + ndc_pkg::RING_LAST) % ndc_pkg::RING_SIZE];
			c_pair[k] = item.nvalid[k] && (item.cmatch || item.nmatch[k]);
			c_join[k] = item.cmatch && item.nmatch[k];
			r_pair[k] = item.nvalid[k] && prev_v[k] && (item.nmatch[k] || prev_m[k]);
			r_join[k] = item.nmatch[k] && prev_m[k];
		end
		c_den = CW'($countones(c_pair)) + CW'($countones(r_pair));
		c_num = CW'($countones(c_join)) + CW'($countones(r_join));
		if (mean_mode) begin
			d_num = CW'($countones(item.nmatch)) + CW'(item.cmatch);
			d_den = CW'($countones(item.nvalid)) + CW'(1);
		end else begin
			d_num = CW'(item.cmatch);
			d_den = CW'(1);
		end
	end

	// Stage 2: counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && item_valid) begin
			d_num_s2 <= d_num;
			d_den_s2 <= d_den;
			c_num_s2 <= c_num;
			c_den_s2 <= c_den;
		end
	end

	// Stage 3: multiply each numerator by the divisor's reciprocal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			d_prod_s3 <= PW'(d_num_s2) * PW'(ndc_pkg::RECIP_TAB[d_den_s2]);
			c_prod_s3 <= PW'(c_num_s2) * PW'(ndc_pkg::RECIP_TAB[c_den_s2]);
		end
	end

	// Output register: drop the guard bits and hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s3) begin
			density_q      <= d_prod_s3[RS +: OW];
			connectivity_q <= c_prod_s3[RS +: OW];
		end
	end

	assign out_valid    = out_valid_q;
	assign density      = density_q;
	assign connectivity = connectivity_q;

endmodule

// ----- rtl/neighbourhood_density_connectivity.sv -----
// Top level: 3x3 neighbourhood density and connectivity of a target class.
//
// Input channel (in_valid/in_ready): one beat is a centre class, eight
// neighbour classes in clockwise ring order, a neighbour valid mask and a
// centre valid flag. Output channel (out_valid/out_ready): one beat per
// input beat carrying density and connectivity in Q1.15 (32768 = 1.0),
// truncated toward zero, in input order.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 sets
// target_class, index 1 sets the mean mode; other indexes are ignored.
// Write configuration only while no beat is in flight.
// Throughput is one beat per cycle while out_ready is high: a register
// stage classifies, a two-entry queue sits between the front and back ends,
// and the back end counts, multiplies by a reciprocal table and registers
// the result.
// Reset clears all valid flags and sets target_class to 0 with mean mode on.
// When out_ready is low the output beat holds, the pipeline and queue fill,
// and in_ready falls once no stage can take another beat.
module neighbourhood_density_connectivity (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ndc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ndc_pkg::FIELD_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ndc_pkg::FIELD_W-1:0]     center_class,
	input  logic [ndc_pkg::FIELD_W-1:0]     nb0_class,
	input  logic [ndc_pkg::FIELD_W-1:0]     nb1_class,
	input  logic [ndc_pkg::FIELD_W-1:0]     nb2_class,
	input  logic [ndc_pkg::FIELD_W-1:0]     nb3_class,
	input  logic [ndc_pkg::FIELD_W-1:0]     nb4_class,
	input  logic [ndc_pkg::FIELD_W-1:0]     nb5_class,
	input  logic [ndc_pkg::FIELD_W-1:0]     nb6_class,
	input  logic [ndc_pkg::FIELD_W-1:0]     nb7_class,
	input  logic [ndc_pkg::RING_SIZE-1:0]   neighbour_valid,
	input  logic                            center_valid,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ndc_pkg::OUT_W-1:0]       density,
	output logic [ndc_pkg::OUT_W-1:0]       connectivity
);

	logic [ndc_pkg::FIELD_W-1:0] target_class_q;
	logic                        mean_mode_q;
	logic [ndc_pkg::FIELD_W-1:0] nb_class [ndc_pkg::RING_SIZE];

	logic                 f_valid;
	logic                 f_ready;
	ndc_pkg::class_item_t f_item;
	logic                 q_valid;
	logic                 q_ready;
	ndc_pkg::class_item_t q_item;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_class_q <= '0;
			mean_mode_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				ndc_pkg::REG_TARGET_CLASS: target_class_q <= cfg_data;
				ndc_pkg::REG_MEAN_MODE:    mean_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign nb_class[0] = nb0_class;
	assign nb_class[1] = nb1_class;
	assign nb_class[2] = nb2_class;
	assign nb_class[3] = nb3_class;
	assign nb_class[4] = nb4_class;
	assign nb_class[5] = nb5_class;
	assign nb_class[6] = nb6_class;
	assign nb_class[7] = nb7_class;

	ndc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.target_class    (target_class_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.center_class    (center_class),
		.nb_class        (nb_class),
		.neighbour_valid (neighbour_valid),
		.center_valid    (center_valid),
		.item_valid      (f_valid),
		.item_ready      (f_ready),
		.item            (f_item)
	);

	ndc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	ndc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mean_mode    (mean_mode_q),
		.item_valid   (q_valid),
		.item_ready   (q_ready),
		.item         (q_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.density      (density),
		.connectivity (connectivity)
	);

endmodule
